FILE: hw/rtl/aspd_pkg.sv
package aspd_pkg;

    localparam int SAMPLE_W = 16;
    localparam int TICK_W = 32;
    localparam int WCOUNT_W = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam int AVG_DEPTH_DEFAULT = 16;
    localparam int MAX_WINDOW_LEN_DEFAULT = 150;

    localparam logic signed [SAMPLE_W-1:0] ONE_G = 16'sd4096;
    localparam logic signed [SAMPLE_W-1:0] WINDOW_MAX_INIT = 16'sh8000;

    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_STEP_INTERVAL = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_STEP_INTERVAL = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD_FLOOR = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_GRAVITY_LEVEL = 2'd3;

    localparam logic [15:0] MIN_STEP_INTERVAL_RESET = 16'd10;
    localparam logic [15:0] MAX_STEP_INTERVAL_RESET = 16'd100;
    localparam logic signed [15:0] THRESHOLD_FLOOR_RESET = 16'sd4178;
    localparam logic signed [15:0] GRAVITY_LEVEL_RESET = 16'sd4096;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       sample_invalid;
    } item_t;

    typedef struct packed {
        logic                       step;
        logic signed [SAMPLE_W-1:0] current_threshold;
    } result_t;

    typedef struct packed {
        logic [15:0]        min_step_interval;
        logic [15:0]        max_step_interval;
        logic signed [15:0] threshold_floor;
        logic signed [15:0] gravity_level;
    } cfg_t;

    typedef struct packed {
        logic advance;
        logic has_sample;
    } ctl_t;

endpackage

FILE: hw/rtl/aspd_ram.sv
module aspd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hw/rtl/aspd_avg.sv
module aspd_avg #(
    parameter int AVG_DEPTH = aspd_pkg::AVG_DEPTH_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 issue,
    input  aspd_pkg::ctl_t                       ctl,
    input  logic signed [aspd_pkg::SAMPLE_W-1:0] x,
    output logic signed [aspd_pkg::SAMPLE_W-1:0] filtered
);

    import aspd_pkg::*;

    localparam int AW = $clog2(AVG_DEPTH);
    localparam int SUMW = SAMPLE_W + AW;
    localparam int MW = SUMW + 2;
    localparam int DIV_SHIFT = SUMW + AW;
    localparam logic signed [SUMW-1:0] SUM_INIT = SUMW'(AVG_DEPTH * 4096);
    localparam logic signed [SUMW:0] OFFSET = (SUMW + 1)'(AVG_DEPTH * 32768);
    localparam logic [MW-1:0] RECIP =
        MW'(((64'd1 << DIV_SHIFT) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH));

    logic [AW-1:0]              ptr_reg;
    logic [AW-1:0]              ptr_next;
    logic [AW-1:0]              addr_reg;
    logic [AVG_DEPTH-1:0]       written_reg;
    logic signed [SUMW-1:0]     sum_reg;
    logic signed [SUMW-1:0]     sum_next;
    logic [SAMPLE_W-1:0]        rdata;
    logic signed [SAMPLE_W-1:0] oldest;
    logic signed [SUMW:0]       biased;
    logic [SUMW+MW-1:0]         product;
    logic [SAMPLE_W-1:0]        quotient;
    logic                       commit;

    assign commit = ctl.advance && ctl.has_sample;

    aspd_ram #(
        .WIDTH(SAMPLE_W),
        .DEPTH(AVG_DEPTH)
    ) u_history (
        .clk  (clk),
        .we   (commit),
        .waddr(addr_reg),
        .wdata(x),
        .re   (issue),
        .raddr(ptr_reg),
        .rdata(rdata)
    );

    always_comb
    begin
        ptr_next = (ptr_reg == AW'(AVG_DEPTH - 1)) ? '0 : ptr_reg + 1'b1;
        oldest = written_reg[addr_reg] ? $signed(rdata) : ONE_G;
        sum_next = sum_reg - SUMW'(oldest) + SUMW'(x);
        biased = (SUMW + 1)'(sum_next) + OFFSET;
        product = (SUMW + MW)'(biased[SUMW-1:0]) * (SUMW + MW)'(RECIP);
        quotient = product[DIV_SHIFT +: SAMPLE_W];
        filtered = $signed({~quotient[SAMPLE_W-1], quotient[SAMPLE_W-2:0]});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg <= '0;
            written_reg <= '0;
            sum_reg <= SUM_INIT;
        end
        else
        begin
            if (issue)
            begin
                ptr_reg <= ptr_next;
            end
            if (commit)
            begin
                written_reg[addr_reg] <= 1'b1;
                sum_reg <= sum_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            addr_reg <= ptr_reg;
        end
    end

endmodule

FILE: hw/rtl/aspd_peak.sv
module aspd_peak #(
    parameter int MAX_WINDOW_LEN = aspd_pkg::MAX_WINDOW_LEN_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  aspd_pkg::ctl_t                       ctl,
    input  aspd_pkg::cfg_t                       cfg,
    input  logic signed [aspd_pkg::SAMPLE_W-1:0] filtered,
    output aspd_pkg::result_t                    result_next
);

    import aspd_pkg::*;

    logic [TICK_W-1:0]          tick_reg;
    logic [TICK_W-1:0]          tick_next;
    logic [TICK_W-1:0]          last_peak_reg;
    logic [TICK_W-1:0]          delta;
    logic [WCOUNT_W-1:0]        wcount_reg;
    logic [WCOUNT_W-1:0]        wcount_inc;
    logic [WCOUNT_W-1:0]        wcount_next;
    logic signed [SAMPLE_W-1:0] wmax_reg;
    logic signed [SAMPLE_W-1:0] wmax_upd;
    logic signed [SAMPLE_W-1:0] wmax_next;
    logic signed [SAMPLE_W-1:0] thr_reg;
    logic signed [SAMPLE_W-1:0] thr_next;
    logic signed [SAMPLE_W-1:0] thr_half;
    logic signed [SAMPLE_W-1:0] thr_cand;
    logic signed [SAMPLE_W:0]   thr_sum;
    logic signed [SAMPLE_W-1:0] last_filt_reg;
    logic                       rising_reg;
    logic                       win_done;
    logic                       going_up;
    logic                       peak;
    logic                       step;
    logic                       commit;

    assign commit = ctl.advance && ctl.has_sample;

    always_comb
    begin
        tick_next = tick_reg + 1'b1;
        wmax_upd = (filtered > wmax_reg) ? filtered : wmax_reg;
        wcount_inc = wcount_reg + 1'b1;
        win_done = wcount_inc >= WCOUNT_W'(MAX_WINDOW_LEN);
        thr_sum = (SAMPLE_W + 1)'(wmax_upd) + (SAMPLE_W + 1)'(cfg.gravity_level);
        thr_half = thr_sum[SAMPLE_W:1];
        thr_cand = (thr_half < cfg.threshold_floor) ? cfg.threshold_floor : thr_half;
        wmax_next = win_done ? WINDOW_MAX_INIT : wmax_upd;
        wcount_next = win_done ? '0 : wcount_inc;
        thr_next = win_done ? thr_cand : thr_reg;
        going_up = filtered >= last_filt_reg;
        delta = tick_next - last_peak_reg;
        peak = !going_up && rising_reg && (last_filt_reg >= thr_next);
        step = peak && (delta > TICK_W'(cfg.min_step_interval))
            && (delta < TICK_W'(cfg.max_step_interval));
        result_next.step = ctl.has_sample && step;
        result_next.current_threshold = ctl.has_sample ? thr_next : thr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg <= '0;
            last_peak_reg <= '0;
            wcount_reg <= '0;
            wmax_reg <= WINDOW_MAX_INIT;
            thr_reg <= THRESHOLD_FLOOR_RESET;
            last_filt_reg <= ONE_G;
            rising_reg <= 1'b0;
        end
        else
        begin
            if (ctl.advance)
            begin
                tick_reg <= tick_next;
            end
            if (commit)
            begin
                wcount_reg <= wcount_next;
                wmax_reg <= wmax_next;
                thr_reg <= thr_next;
                last_filt_reg <= filtered;
                rising_reg <= going_up;
                if (peak)
                begin
                    last_peak_reg <= tick_next;
                end
            end
        end
    end

endmodule

FILE: hw/rtl/accel_step_peak_detector.sv
// Step detector for a pedometer: one beat carries one acceleration-magnitude sample and
// yields one beat with the step flag and the threshold in force. The block takes a new
// beat every cycle while item_stall is low. A valid beat reads the oldest sample of the
// moving-average history memory in the cycle it is taken. When the beat leaves stage 1,
// a valid beat updates the running sum, window maximum, threshold and peak state, and
// every beat loads the result register. Each valid beat reads and writes the history
// memory once, and an invalid beat leaves it untouched. The input is stalled only while
// a beat waits in the stage behind the input and the result register is full and held
// by the consumer. The threshold and gravity registers take effect at the next window
// completion.
module accel_step_peak_detector #(
    parameter int AVG_DEPTH = aspd_pkg::AVG_DEPTH_DEFAULT,
    parameter int MAX_WINDOW_LEN = aspd_pkg::MAX_WINDOW_LEN_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  aspd_pkg::item_t                  item,
    input  logic                             item_valid,
    output logic                             item_stall,
    output aspd_pkg::result_t                result,
    output logic                             result_valid,
    input  logic                             result_stall,
    input  logic                             cfg_we,
    input  logic [aspd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [aspd_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import aspd_pkg::*;

    cfg_t    cfg_reg;
    item_t   s1_item_reg;
    logic    s1_valid_reg;
    logic    s1_adv;
    logic    accept;
    ctl_t    ctl;
    result_t result_reg;
    result_t result_next;
    logic    result_valid_reg;
    logic signed [SAMPLE_W-1:0] filtered;

    assign s1_adv = s1_valid_reg && (!result_valid_reg || !result_stall);
    assign item_stall = s1_valid_reg && !s1_adv;
    assign accept = item_valid && !item_stall;
    assign ctl.advance = s1_adv;
    assign ctl.has_sample = !s1_item_reg.sample_invalid;
    assign result = result_reg;
    assign result_valid = result_valid_reg;

    aspd_avg #(
        .AVG_DEPTH(AVG_DEPTH)
    ) u_avg (
        .clk     (clk),
        .rst_n   (rst_n),
        .issue   (accept && !item.sample_invalid),
        .ctl     (ctl),
        .x       (s1_item_reg.sample),
        .filtered(filtered)
    );

    aspd_peak #(
        .MAX_WINDOW_LEN(MAX_WINDOW_LEN)
    ) u_peak (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .cfg        (cfg_reg),
        .filtered   (filtered),
        .result_next(result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_step_interval <= MIN_STEP_INTERVAL_RESET;
            cfg_reg.max_step_interval <= MAX_STEP_INTERVAL_RESET;
            cfg_reg.threshold_floor <= THRESHOLD_FLOOR_RESET;
            cfg_reg.gravity_level <= GRAVITY_LEVEL_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MIN_STEP_INTERVAL: cfg_reg.min_step_interval <= cfg_data;
                CFG_MAX_STEP_INTERVAL: cfg_reg.max_step_interval <= cfg_data;
                CFG_THRESHOLD_FLOOR:   cfg_reg.threshold_floor <= $signed(cfg_data);
                CFG_GRAVITY_LEVEL:     cfg_reg.gravity_level <= $signed(cfg_data);
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= item;
        end
        if (s1_adv)
        begin
            result_reg <= result_next;
        end
    end

    a_hold_stage1: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_adv |=> s1_valid_reg && $stable(s1_item_reg))
        else $error("stage 1 beat lost while the result side was stalled");

    a_adv_fills_result: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> result_valid_reg)
        else $error("advanced beat did not reach the result register");

    a_accept_fills_stage1: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("accepted beat did not enter stage 1");

    a_stall_needs_full: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> s1_valid_reg && result_valid_reg && result_stall)
        else $error("input stalled without a blocked pipeline");

endmodule

FILE: tb/accel_step_peak_detector_test.sv
module accel_step_peak_detector_test;

    import aspd_pkg::*;

    localparam int HIST_DEPTH = AVG_DEPTH_DEFAULT;
    localparam int WINDOW_LEN = MAX_WINDOW_LEN_DEFAULT;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 60;
    localparam int PRINT_CAP = 40;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    item_t item = '0;
    logic item_valid = 1'b0;
    logic item_stall;
    result_t result;
    logic result_valid;
    logic result_stall = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_MIN_STEP_INTERVAL;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    accel_step_peak_detector uut (
        .clk(clk),
        .rst_n(rst_n),
        .item(item),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .result(result),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    item_t samples_to_send[$];
    result_t step_predictions[$];
    int queued_count = 0;
    int valid_queued = 0;
    int accepted_count = 0;
    int mismatches = 0;
    int send_gap_pct = 0;
    int stall_pct = 0;
    int hold_requests = 0;
    bit beat_taken = 1'b0;

    // Detector state mirrored from the block.
    logic [15:0] min_gap = MIN_STEP_INTERVAL_RESET;
    logic [15:0] max_gap = MAX_STEP_INTERVAL_RESET;
    logic signed [15:0] thr_floor = THRESHOLD_FLOOR_RESET;
    logic signed [15:0] gravity = GRAVITY_LEVEL_RESET;
    int history [HIST_DEPTH] = '{default: 4096};
    int history_sum = 4096 * HIST_DEPTH;
    int history_ptr = 0;
    int window_fill = 0;
    int window_peak = -32768;
    int threshold = 4178;
    int prev_avg = 4096;
    bit rising = 1'b0;
    logic [31:0] tick = '0;
    logic [31:0] last_peak = '0;

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic result_t detect_step(item_t beat);
        result_t r;
        int x;
        int avg;
        int level;
        bit hit;
        logic [31:0] gap;
        hit = 1'b0;
        tick = tick + 32'd1;
        if (!beat.sample_invalid)
        begin
            x = beat.sample;
            history_sum = history_sum - history[history_ptr] + x;
            history[history_ptr] = x;
            history_ptr = (history_ptr + 1) % HIST_DEPTH;
            avg = history_sum >>> $clog2(HIST_DEPTH);
            if (avg > window_peak)
                window_peak = avg;
            window_fill = (window_fill + 1) & 8'hFF;
            if (window_fill >= WINDOW_LEN)
            begin
                level = (window_peak + int'(gravity)) >>> 1;
                if (level < int'(thr_floor))
                    level = thr_floor;
                threshold = level;
                window_fill = 0;
                window_peak = -32768;
            end
            if (avg >= prev_avg)
                rising = 1'b1;
            else
            begin
                if (rising && prev_avg >= threshold)
                begin
                    gap = tick - last_peak;
                    hit = (gap > {16'd0, min_gap}) && (gap < {16'd0, max_gap});
                    last_peak = tick;
                end
                rising = 1'b0;
            end
            prev_avg = avg;
        end
        r.step = hit;
        r.current_threshold = 16'(threshold);
        return r;
    endfunction

    task automatic flag_mismatch(string what, int got, int want);
        if (mismatches < PRINT_CAP)
            $display("mismatch at %0t: %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (step_predictions.size() == 0)
                    flag_mismatch("result beat with nothing expected", int'(result), 0);
                else
                begin
                    want = step_predictions.pop_front();
                    if (result.step !== want.step)
                        flag_mismatch("step", int'(result.step), int'(want.step));
                    if (result.current_threshold !== want.current_threshold)
                        flag_mismatch("current_threshold", int'(result.current_threshold),
                                      int'(want.current_threshold));
                end
            end
            beat_taken = item_valid && !item_stall;
            if (beat_taken)
            begin
                step_predictions.push_back(detect_step(item));
                accepted_count++;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MIN_STEP_INTERVAL: min_gap = cfg_data;
                    CFG_MAX_STEP_INTERVAL: max_gap = cfg_data;
                    CFG_THRESHOLD_FLOOR: thr_floor = cfg_data;
                    CFG_GRAVITY_LEVEL: gravity = cfg_data;
                    default: ;
                endcase
            end
        end
        else
            beat_taken = 1'b0;
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            item_valid <= 1'b0;
        else if (!item_valid || beat_taken)
        begin
            if (samples_to_send.size() != 0 && $urandom_range(0, 99) >= send_gap_pct)
            begin
                item <= samples_to_send.pop_front();
                item_valid <= 1'b1;
            end
            else
                item_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        int hold_seen;
        int hold_left;
        if (hold_seen != hold_requests)
        begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else
            result_stall <= $urandom_range(0, 99) < stall_pct;
    end

    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("accel_step_peak_detector_test: done, errors");
        $finish;
    end

    task automatic push_sample(int v, bit bad);
        item_t it;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        it.sample = 16'(v);
        it.sample_invalid = bad;
        samples_to_send.push_back(it);
        queued_count++;
        if (!bad)
            valid_queued++;
    endtask

    task automatic queue_walking(int target);
        int start;
        int kind;
        int period;
        int amp;
        int base;
        int len;
        int ph;
        int v;
        start = valid_queued;
        while (valid_queued - start < target)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 7)
            begin
                period = $urandom_range(8, 90);
                amp = $urandom_range(300, 14000);
                base = $urandom_range(2048, 6144);
                len = period * $urandom_range(2, 4);
                for (int k = 0; k < len; k++)
                begin
                    ph = k % period;
                    if (2 * ph < period)
                        v = base + amp * 2 * ph / period;
                    else
                        v = base + amp * 2 * (period - ph) / period;
                    v = v + int'($urandom_range(0, amp / 8)) - amp / 16;
                    push_sample(v, $urandom_range(0, 49) == 0);
                    if (valid_queued - start >= target)
                        break;
                end
            end
            else if (kind == 7)
            begin
                v = int'($urandom_range(0, 65535)) - 32768;
                len = $urandom_range(3, 20);
                for (int k = 0; k < len; k++)
                    push_sample(v, 1'b0);
            end
            else
            begin
                len = $urandom_range(3, 20);
                for (int k = 0; k < len; k++)
                    push_sample(int'($urandom_range(0, 65535)) - 32768,
                                $urandom_range(0, 3) == 0);
            end
        end
    endtask

    task automatic wait_for_results();
        while (accepted_count != queued_count || step_predictions.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, int val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= 16'(val);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_limits(int lo, int hi, int flr, int grav);
        write_reg(CFG_MIN_STEP_INTERVAL, lo);
        write_reg(CFG_MAX_STEP_INTERVAL, hi);
        write_reg(CFG_THRESHOLD_FLOOR, flr);
        write_reg(CFG_GRAVITY_LEVEL, grav);
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        @(posedge clk);
        push_sample(32767, 1'b0);
        push_sample(32767, 1'b0);
        push_sample(32767, 1'b0);
        push_sample(-32768, 1'b0);
        push_sample(-32768, 1'b0);
        push_sample(-32768, 1'b0);
        push_sample(-1, 1'b0);
        push_sample(0, 1'b0);
        push_sample(32767, 1'b1);
        push_sample(-32768, 1'b1);
        for (int k = 0; k < 7; k++)
            push_sample(12000, 1'b0);
        for (int k = 0; k < 6; k++)
            push_sample(0, 1'b0);
        push_sample(4096, 1'b0);
        push_sample(4096, 1'b0);
        wait_for_results();

        for (int phase = 1; phase <= 10; phase++)
        begin
            case (phase % 4)
                0: begin send_gap_pct = 0; stall_pct = 0; end
                1: begin send_gap_pct = 60; stall_pct = 0; end
                2: begin send_gap_pct = 0; stall_pct = 60; end
                default: begin send_gap_pct = 17; stall_pct = 17; end
            endcase
            case (phase)
                1: set_limits(10, 100, 4178, 4096);
                2: set_limits(0, 65535, -32768, -32768);
                3: set_limits(65535, 0, 32767, 32767);
                4: set_limits(5, 60, 4178, 4096);
                6: set_limits(0, 0, -32768, 32767);
                7: set_limits(20, 80, 0, 4096);
                9: set_limits(8, 120, 2048, 4096);
                default: set_limits($urandom_range(0, 20), $urandom_range(30, 200),
                                    $urandom_range(2000, 7000), $urandom_range(3000, 5000));
            endcase
            @(posedge clk);
            queue_walking(110);
            if (phase == 4)
                hold_requests++;
            wait_for_results();
        end

        repeat (6) @(negedge clk);
        if (mismatches == 0)
            $display("accel_step_peak_detector_test: done, clean");
        else
            $display("accel_step_peak_detector_test: done, errors");
        $finish;
    end

endmodule
